// ===== hw/rtl/banked_memory_map_with_vram_planes_unit_defines.svh =====
// Assertion helpers for the memory map RTL.
`ifndef BANKED_MEMORY_MAP_WITH_VRAM_PLANES_UNIT_DEFINES_SVH
`define BANKED_MEMORY_MAP_WITH_VRAM_PLANES_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("memory map assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("memory map assertion failed");

`endif

// ===== hw/rtl/bmm_pkg.sv =====
`default_nettype none

package bmm_pkg;

  // Bus operation codes
  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_IO_WRITE = 2'd2,
    OP_ROM_LOAD = 2'd3
  } op_e;

  // Decoded address regions
  typedef enum logic [2:0] {
    RG_BOOT,
    RG_CART,
    RG_EXP,
    RG_MAIN,
    RG_VIDEO
  } region_e;

  // Per-item info carried alongside the memory read stage
  typedef struct packed {
    logic    is_read;
    region_e region;
    logic    vid_ok;
  } s1_info_t;

  // Map layout
  localparam logic [15:0] CART_BASE  = 16'h2000;
  localparam logic [15:0] EXP_BASE   = 16'h6000;
  localparam logic [15:0] MAIN_BASE  = 16'hB000;
  localparam logic [15:0] VIDEO_BASE = 16'hEEC0;

  localparam int unsigned BOOT_SIZE = 32'h2000;
  localparam int unsigned CART_SIZE = 32'h4000;
  localparam int unsigned EXP_SIZE  = 32'h5000;
  localparam int unsigned MAIN_SIZE = 32'h4000;

  localparam int unsigned BOOT_AW = 13;
  localparam int unsigned CART_AW = 14;
  localparam int unsigned EXP_AW  = 15;
  localparam int unsigned MAIN_AW = 14;

  // I/O ports
  localparam logic [7:0] PORT_READ_PAGE  = 8'hF1;
  localparam logic [7:0] PORT_WRITE_MASK = 8'hF2;

  localparam logic [7:0] ROM_FILL  = 8'hFF;
  localparam logic [7:0] OPEN_BUS  = 8'hFF;

  // Address decode
  function automatic region_e region_of(input logic [15:0] a);
    region_e r;
    case (a) inside
      [16'h0000:16'h1FFF]: r = RG_BOOT;
      [16'h2000:16'h5FFF]: r = RG_CART;
      [16'h6000:16'hAFFF]: r = RG_EXP;
      [16'hB000:16'hEEBF]: r = RG_MAIN;
      default:             r = RG_VIDEO;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/banked_memory_map_with_vram_planes_unit.sv =====
// Pipeline: memory read stage, then result register.
// Throughput: one item per cycle; a stalled result stops the input once the read stage is full.
// Reset: rst_ni (async, active low) clears control state, then a clearing pass over the
// expansion RAM depth writes the reset contents of all memories, one entry per memory
// per cycle; no item is accepted during that pass.
`default_nettype none
`include "banked_memory_map_with_vram_planes_unit_defines.svh"

module banked_memory_map_with_vram_planes_unit
  import bmm_pkg::*;
#(
  parameter int unsigned PLANE_BYTES = 8192,
  parameter int unsigned PLANE_COUNT = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o,
  output logic             read_valid_o
);

  localparam int unsigned PB_AW  = $clog2(PLANE_BYTES);
  localparam int unsigned PSEL_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int unsigned CLR_W  = EXP_AW;

  // Clearing pass after reset
  logic             clr_busy_q, clr_busy_d;
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;

  // Pipeline control
  logic acc, s2_load;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  // Decode of the incoming item
  op_e         op;
  region_e     region;
  logic [15:0] cart_off, exp_off, main_off, vid_off;
  logic [PB_AW-1:0] vid_idx;
  logic        vid_in_range, page_ok;
  logic [PSEL_W-1:0] psel;
  logic        rd_en, wr_en, load_en;

  // Mode registers
  logic [7:0] read_page_q;
  logic [5:0] write_mask_q;

  // Stage 1 registers
  s1_info_t          s1_q;
  logic [PSEL_W-1:0] psel_q;
  logic [7:0]        boot_rd_q, cart_rd_q, exp_rd_q, main_rd_q;
  logic [7:0]        plane_rd_q [PLANE_COUNT];

  // Result register
  logic [7:0] read_data_q, read_data_d;
  logic       read_valid_q;

  // Handshake
  assign s2_load    = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || (s1_valid_q && !s2_load);
  assign acc        = in_valid_i && !in_stall_o;

  // Decode
  assign op           = op_e'(op_i);
  assign region       = region_of(address_i);
  assign cart_off     = address_i - CART_BASE;
  assign exp_off      = address_i - EXP_BASE;
  assign main_off     = address_i - MAIN_BASE;
  assign vid_off      = address_i - VIDEO_BASE;
  assign vid_idx      = vid_off[PB_AW-1:0];
  assign vid_in_range = vid_off < 16'(PLANE_BYTES);
  assign page_ok      = (read_page_q != 8'd0) && (read_page_q <= 8'(PLANE_COUNT));
  assign psel         = PSEL_W'(read_page_q - 8'd1);
  assign rd_en        = acc && (op == OP_READ);
  assign wr_en        = acc && (op == OP_WRITE);
  assign load_en      = acc && (op == OP_ROM_LOAD);

  // Clear counter
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + CLR_W'(1);
      if (clr_cnt_q == CLR_W'(EXP_SIZE - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // I/O port registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_page_q  <= '0;
      write_mask_q <= '0;
    end else if (acc && (op == OP_IO_WRITE)) begin
      if (address_i[7:0] == PORT_READ_PAGE) begin
        read_page_q <= write_data_i;
      end else if (address_i[7:0] == PORT_WRITE_MASK) begin
        write_mask_q <= write_data_i[5:0];
      end
    end
  end

  // Boot ROM: loadable, read-only on the bus
  logic [7:0] boot_mem [BOOT_SIZE];
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      if (clr_cnt_q < CLR_W'(BOOT_SIZE)) begin
        boot_mem[clr_cnt_q[BOOT_AW-1:0]] <= ROM_FILL;
      end
    end else if (load_en && (region == RG_BOOT)) begin
      boot_mem[address_i[BOOT_AW-1:0]] <= write_data_i;
    end
    if (rd_en && (region == RG_BOOT)) begin
      boot_rd_q <= boot_mem[address_i[BOOT_AW-1:0]];
    end
  end

  // Cartridge ROM
  logic [7:0] cart_mem [CART_SIZE];
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      if (clr_cnt_q < CLR_W'(CART_SIZE)) begin
        cart_mem[clr_cnt_q[CART_AW-1:0]] <= ROM_FILL;
      end
    end else if (load_en && (region == RG_CART)) begin
      cart_mem[cart_off[CART_AW-1:0]] <= write_data_i;
    end
    if (rd_en && (region == RG_CART)) begin
      cart_rd_q <= cart_mem[cart_off[CART_AW-1:0]];
    end
  end

  // Expansion RAM (sets the clear pass length)
  logic [7:0] exp_mem [EXP_SIZE];
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      exp_mem[clr_cnt_q] <= 8'h00;
    end else if (wr_en && (region == RG_EXP)) begin
      exp_mem[exp_off[EXP_AW-1:0]] <= write_data_i;
    end
    if (rd_en && (region == RG_EXP)) begin
      exp_rd_q <= exp_mem[exp_off[EXP_AW-1:0]];
    end
  end

  // Main RAM
  logic [7:0] main_mem [MAIN_SIZE];
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      if (clr_cnt_q < CLR_W'(MAIN_SIZE)) begin
        main_mem[clr_cnt_q[MAIN_AW-1:0]] <= 8'h00;
      end
    end else if (wr_en && (region == RG_MAIN)) begin
      main_mem[main_off[MAIN_AW-1:0]] <= write_data_i;
    end
    if (rd_en && (region == RG_MAIN)) begin
      main_rd_q <= main_mem[main_off[MAIN_AW-1:0]];
    end
  end

  // Video planes: one memory per plane, writes broadcast by mask
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    logic [7:0] mem [PLANE_BYTES];
    always_ff @(posedge clk_i) begin
      if (clr_busy_q) begin
        if (clr_cnt_q < CLR_W'(PLANE_BYTES)) begin
          mem[clr_cnt_q[PB_AW-1:0]] <= 8'h00;
        end
      end else if (wr_en && (region == RG_VIDEO) && vid_in_range && write_mask_q[p]) begin
        mem[vid_idx] <= write_data_i;
      end
      if (rd_en && (region == RG_VIDEO) && vid_in_range) begin
        plane_rd_q[p] <= mem[vid_idx];
      end
    end
  end

  // Stage 1 control
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Stage 1 item info
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q.is_read <= (op == OP_READ);
      s1_q.region  <= region;
      s1_q.vid_ok  <= page_ok && vid_in_range;
      psel_q       <= psel;
    end
  end

  // Result select
  always_comb begin
    read_data_d = 8'h00;
    if (s1_q.is_read) begin
      case (s1_q.region)
        RG_BOOT:  read_data_d = boot_rd_q;
        RG_CART:  read_data_d = cart_rd_q;
        RG_EXP:   read_data_d = exp_rd_q;
        RG_MAIN:  read_data_d = main_rd_q;
        RG_VIDEO: read_data_d = s1_q.vid_ok ? plane_rd_q[psel_q] : OPEN_BUS;
        default:  read_data_d = OPEN_BUS;
      endcase
    end
  end

  // Result register
  assign out_valid_d = s2_load ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      read_data_q  <= read_data_d;
      read_valid_q <= s1_q.is_read;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign read_valid_o = read_valid_q;

  // Checks
  `BMM_ASSERT_IMP(a_clear_pipe_empty, clr_busy_q, !s1_valid_q && !out_valid_q)
  `BMM_ASSERT_IMP(a_clear_cnt_range, clr_busy_q, clr_cnt_q < CLR_W'(EXP_SIZE))
  `BMM_ASSERT_NXT(a_s1_held, s1_valid_q && !s2_load, s1_valid_q)
  `BMM_ASSERT_IMP(a_nonread_zero, out_valid_q && !read_valid_q, read_data_q == 8'h00)

endmodule

`default_nettype wire
